[rtl/core/fdsa_pkg.sv]
// Package for the Forth data stack ALU: opcodes, status codes, FSM states,
// controller/datapath command and status structs. No dependencies.
package fdsa_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] OP_PUSH   = 4'd0;
    localparam logic [3:0] OP_ADD    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_DIV    = 4'd4;
    localparam logic [3:0] OP_DIVMOD = 4'd5;
    localparam logic [3:0] OP_SWAP   = 4'd6;
    localparam logic [3:0] OP_DUP    = 4'd7;
    localparam logic [3:0] OP_ROT    = 4'd8;
    localparam logic [3:0] OP_DROP   = 4'd9;
    localparam logic [3:0] OP_PRINT  = 4'd10;
    localparam logic [3:0] OP_EMIT   = 4'd11;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_T, S_RD_S, S_RD_X, S_WAIT, S_EXEC,
        S_MUL, S_DIV, S_WR1, S_WR2, S_WR3, S_OUT
    } t_state;

    // read/write selectors relative to the current depth
    typedef enum logic [1:0] { SEL_D1, SEL_D2, SEL_D3, SEL_D0 } t_sel;

    typedef enum logic [2:0] {
        WV_LIT, WV_T, WV_S, WV_X, WV_ALU, WV_Q, WV_R
    } t_wval;

    typedef struct packed {
        logic  load;      // latch op and literal
        logic  rd_en;
        t_sel  rd_sel;
        logic  cap_t;
        logic  cap_s;
        logic  cap_x;
        logic  exec;      // register add/sub result
        logic  mul_go;
        logic  mul_step;
        logic  div_go;
        logic  wr_en;
        t_sel  wr_sel;
        t_wval wr_val;
        logic  set_depth;
        logic [DW-1:0] depth_val;
        logic  set_res;
        logic [1:0] status;
        logic  pv;
        logic  ev;
    } t_cmd;

    typedef struct packed {
        logic [3:0]    op;
        logic [DW-1:0] depth;
        logic          t_zero;
        logic          div_done;
    } t_stat;
endpackage

[rtl/core/fdsa_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module fdsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/fdsa_div.sv]
// Radix-2 signed divider, one quotient bit per cycle, truncating.
// Depends on fdsa_pkg.
module fdsa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    import fdsa_pkg::*;
    logic [63:0] r_q, r_d;
    logic [64:0] r_r;
    logic [6:0]  r_cnt;
    logic        r_busy, r_qneg, r_rneg;
    logic [64:0] w_shift, w_sub;

    assign w_shift = {r_r[63:0], r_q[63]};
    assign w_sub   = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q    <= i_num[63] ? 64'd0 - i_num : i_num;
            r_d    <= i_den[63] ? 64'd0 - i_den : i_den;
            r_r    <= '0;
            r_qneg <= i_num[63] ^ i_den[63];
            r_rneg <= i_num[63];
        end else if (r_busy) begin
            if (!w_sub[64]) begin
                r_r <= w_sub;
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= w_shift;
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_qneg ? 64'd0 - r_q : r_q;
    assign o_rem  = r_rneg ? 64'd0 - r_r[63:0] : r_r[63:0];
endmodule

[rtl/core/fdsa_dp.sv]
// Datapath: stack RAM, depth register, operand registers, ALU, result regs.
// Depends on fdsa_pkg, fdsa_ram, fdsa_div.
module fdsa_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_operation,
    input  logic [63:0]       i_literal,
    input  fdsa_pkg::t_cmd    i_cmd,
    output fdsa_pkg::t_stat   o_stat,
    output logic [1:0]        o_status,
    output logic              o_print_valid,
    output logic [63:0]       o_print_value,
    output logic              o_emit_valid,
    output logic [7:0]        o_emit_char,
    output logic [6:0]        o_depth_after
);
    import fdsa_pkg::*;
    logic [3:0]    r_op;
    logic [63:0]   r_lit, r_t, r_s, r_x, r_alu;
    logic [DW-1:0] r_depth;
    logic [63:0]   w_rdata, w_wdata, w_quo, w_rem;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_div_done;
    // 64x64 low product in three 32x32 partial steps
    logic [1:0]    r_mstep;
    logic [63:0]   r_macc;

    function automatic logic [AW-1:0] f_addr(input logic [DW-1:0] d, input t_sel s);
        logic [DW-1:0] a;
        case (s)
            SEL_D1:  a = d - DW'(1);
            SEL_D2:  a = d - DW'(2);
            SEL_D3:  a = d - DW'(3);
            default: a = d;
        endcase
        return a[AW-1:0];
    endfunction

    assign w_raddr = f_addr(r_depth, i_cmd.rd_sel);
    assign w_waddr = f_addr(r_depth, i_cmd.wr_sel);

    always_comb begin
        case (i_cmd.wr_val)
            WV_LIT:  w_wdata = r_lit;
            WV_T:    w_wdata = r_t;
            WV_S:    w_wdata = r_s;
            WV_X:    w_wdata = r_x;
            WV_ALU:  w_wdata = r_alu;
            WV_Q:    w_wdata = w_quo;
            default: w_wdata = w_rem;
        endcase
    end

    fdsa_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(i_cmd.wr_en), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_re(i_cmd.rd_en), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    fdsa_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.div_go),
        .i_num(r_s), .i_den(r_t), .o_done(w_div_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_depth <= '0;
        else if (i_cmd.set_depth) r_depth <= i_cmd.depth_val;
    end

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_pp;
    always_comb begin
        w_ma = r_mstep[0] ? r_s[63:32] : r_s[31:0];
        w_mb = r_mstep[1] ? r_t[63:32] : r_t[31:0];
        w_pp = w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_lit <= i_literal;
            r_t   <= '0;
            r_s   <= '0;
        end
        if (i_cmd.cap_t) r_t <= w_rdata;
        if (i_cmd.cap_s) r_s <= w_rdata;
        if (i_cmd.cap_x) r_x <= w_rdata;
        if (i_cmd.exec) r_alu <= (r_op == OP_SUB) ? r_s - r_t : r_s + r_t;
        if (i_cmd.mul_go) begin
            r_mstep <= 2'd0;
            r_macc  <= '0;
        end else if (i_cmd.mul_step) begin
            r_mstep <= r_mstep + 2'd1;
            case (r_mstep)
                2'd0:    r_macc <= r_macc + w_pp;
                2'd1:    r_macc <= r_macc + {w_pp[31:0], 32'd0};
                2'd2:    r_macc <= r_macc + {w_pp[31:0], 32'd0};
                default: r_macc <= r_macc;
            endcase
            if (r_mstep == 2'd2) r_alu <= r_macc + {w_pp[31:0], 32'd0};
        end
        if (i_cmd.set_res) begin
            o_status      <= i_cmd.status;
            o_print_valid <= i_cmd.pv;
            o_print_value <= i_cmd.pv ? r_t : 64'd0;
            o_emit_valid  <= i_cmd.ev;
            o_emit_char   <= i_cmd.ev ? r_t[7:0] : 8'd0;
            o_depth_after <= 7'(i_cmd.depth_val);
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.depth    = r_depth;
    assign o_stat.t_zero   = (r_t == 64'd0);
    assign o_stat.div_done = w_div_done;
endmodule

[rtl/core/fdsa_ctrl.sv]
// Controller FSM: sequences reads, ALU, writes and the result beat.
// Depends on fdsa_pkg.
module fdsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  fdsa_pkg::t_stat i_stat,
    output fdsa_pkg::t_cmd  o_cmd
);
    import fdsa_pkg::*;
    t_state r_state, n_state;
    logic [1:0] w_need;
    logic [1:0] r_mcnt, n_mcnt;
    logic       r_ovalid, n_ovalid;
    logic [DW-1:0] d;

    assign d = i_stat.depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mcnt   <= n_mcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        case (i_stat.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVMOD, OP_SWAP: w_need = 2'd2;
            OP_ROT: w_need = 2'd3;
            OP_DUP, OP_DROP, OP_PRINT, OP_EMIT: w_need = 2'd1;
            default: w_need = 2'd0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_mcnt   = r_mcnt;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        o_cmd.depth_val = d;
        o_cmd.wr_val    = WV_LIT;
        o_cmd.status    = ST_OK;
        o_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD_T;
                end
            end
            S_RD_T: begin
                if (d < DW'(w_need)) begin
                    o_cmd.set_depth = 1'b1;
                    o_cmd.depth_val = '0;
                    o_cmd.status    = ST_UNDER;
                    n_state         = S_OUT;
                    if (!r_ovalid || !i_stall) begin
                        o_cmd.set_res = 1'b1;
                        n_ovalid      = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_en  = (d != '0);
                    o_cmd.rd_sel = SEL_D1;
                    n_state      = S_RD_S;
                end
            end
            S_RD_S: begin
                o_cmd.cap_t  = (d != '0);
                o_cmd.rd_en  = (d >= DW'(2));
                o_cmd.rd_sel = SEL_D2;
                n_state      = (i_stat.op == OP_ROT) ? S_RD_X : S_WAIT;
            end
            S_RD_X: begin
                o_cmd.cap_s  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = SEL_D3;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.op == OP_ROT) o_cmd.cap_x = 1'b1;
                else o_cmd.cap_s = (d >= DW'(2));
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_WR1;
                if (i_stat.op == OP_MUL) begin
                    o_cmd.mul_go = 1'b1;
                    n_mcnt       = 2'd0;
                    n_state      = S_MUL;
                end else if ((i_stat.op == OP_DIV || i_stat.op == OP_DIVMOD)
                             && !i_stat.t_zero) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_mcnt         = r_mcnt + 2'd1;
                if (r_mcnt == 2'd2) n_state = S_WR1;
            end
            S_DIV: if (i_stat.div_done) n_state = S_WR1;
            S_WR1: begin
                n_state = S_OUT;
                case (i_stat.op)
                    OP_PUSH, OP_DUP: if (d < DW'(STACK_DEPTH)) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = SEL_D0;
                        o_cmd.wr_val = (i_stat.op == OP_PUSH) ? WV_LIT : WV_T;
                    end
                    OP_ADD, OP_SUB, OP_MUL: begin
                        o_cmd.wr_en = 1'b1; o_cmd.wr_sel = SEL_D2; o_cmd.wr_val = WV_ALU;
                    end
                    OP_DIV: if (!i_stat.t_zero) begin
                        o_cmd.wr_en = 1'b1; o_cmd.wr_sel = SEL_D2; o_cmd.wr_val = WV_Q;
                    end
                    OP_DIVMOD: if (!i_stat.t_zero) begin
                        o_cmd.wr_en = 1'b1; o_cmd.wr_sel = SEL_D2; o_cmd.wr_val = WV_R;
                        n_state = S_WR2;
                    end
                    OP_SWAP, OP_ROT: begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wr_sel = (i_stat.op == OP_ROT) ? SEL_D3 : SEL_D2;
                        o_cmd.wr_val = (i_stat.op == OP_ROT) ? WV_S : WV_T;
                        n_state = S_WR2;
                    end
                    default: ;
                endcase
            end
            S_WR2: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_OUT;
                case (i_stat.op)
                    OP_DIVMOD: begin o_cmd.wr_sel = SEL_D1; o_cmd.wr_val = WV_Q; end
                    OP_SWAP:   begin o_cmd.wr_sel = SEL_D1; o_cmd.wr_val = WV_S; end
                    default: begin
                        o_cmd.wr_sel = SEL_D2; o_cmd.wr_val = WV_T; n_state = S_WR3;
                    end
                endcase
            end
            S_WR3: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = SEL_D1;
                o_cmd.wr_val = WV_X;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_need == 2'd0 || d >= DW'(w_need) || r_state == S_OUT) begin
                    o_cmd.status = ST_OK;
                    case (i_stat.op)
                        OP_PUSH, OP_DUP: if (d >= DW'(STACK_DEPTH)) o_cmd.status = ST_OVER;
                                         else o_cmd.depth_val = d + DW'(1);
                        OP_ADD, OP_SUB, OP_MUL, OP_DROP: o_cmd.depth_val = d - DW'(1);
                        OP_DIV: if (i_stat.t_zero) o_cmd.status = ST_DIVZERO;
                                else o_cmd.depth_val = d - DW'(1);
                        OP_DIVMOD: if (i_stat.t_zero) o_cmd.status = ST_DIVZERO;
                        OP_PRINT: begin o_cmd.pv = 1'b1; o_cmd.depth_val = d - DW'(1); end
                        OP_EMIT:  begin o_cmd.ev = 1'b1; o_cmd.depth_val = d - DW'(1); end
                        default: ;
                    endcase
                    // underflow already zeroed depth: depth 0 below need
                    if (w_need != 2'd0 && d < DW'(w_need)) begin
                        o_cmd.status = ST_UNDER; o_cmd.pv = 1'b0; o_cmd.ev = 1'b0;
                        o_cmd.depth_val = '0;
                    end
                end
                if (!r_ovalid || !i_stall) begin
                    o_cmd.set_res   = 1'b1;
                    o_cmd.set_depth = 1'b1;
                    n_ovalid        = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
endmodule

[rtl/core/forth_data_stack_alu_top.sv]
// Forth data stack ALU. One result beat per input beat, in order, one item at
// a time. An item passes through the accept step, the top and second RAM
// reads (one port, registered read), a wait for read data, the ALU step, the
// write step (one RAM write for ops that write) and the result load. Swap and
// divmod add a second write (divmod only for a nonzero divisor); rot adds a
// third read and two more writes; mul adds three 32x32 partial products; div
// and divmod with a nonzero divisor wait for the one-bit-per-cycle divider.
// An underflow loads its result straight from the depth check when the output
// register is free. A finished result sits in the output register while the
// next item is accepted; the next result then waits in the controller until
// that register is taken, so a stalling receiver holds up the controller.
// Stack contents are undefined until written.
// Depends on fdsa_pkg, fdsa_ctrl, fdsa_dp (fdsa_ram, fdsa_div).
module forth_data_stack_alu_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_operation,
    input  logic [63:0] i_literal,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_print_valid,
    output logic [63:0] o_print_value,
    output logic        o_emit_valid,
    output logic [7:0]  o_emit_char,
    output logic [6:0]  o_depth_after
);
    import fdsa_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;

    // controller: handshakes and sequencing
    fdsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    // datapath: stack, ALU, result register
    fdsa_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_operation(i_operation),
        .i_literal(i_literal), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_status(o_status), .o_print_valid(o_print_valid),
        .o_print_value(o_print_value), .o_emit_valid(o_emit_valid),
        .o_emit_char(o_emit_char), .o_depth_after(o_depth_after)
    );

`ifndef SYNTHESIS
    // a result beat never has both print and emit
    a_one_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_print_valid && o_emit_valid))
        else $error("print and emit both set");
    // depth never exceeds the stack size
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_depth_after <= 7'(STACK_DEPTH)))
        else $error("depth beyond stack size");
    // no new input accepted while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while busy");
`endif
endmodule

[dv/tb_top.sv]
// Testbench for forth_data_stack_alu_top: directed table, fill to overflow, then random beats,
// scoreboarded against an in-bench stack model. Depends on fdsa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import fdsa_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        pv;
        logic [63:0] pval;
        logic        ev;
        logic [7:0]  ech;
        logic [6:0]  depth;
    } t_res;

    typedef struct {
        logic [3:0]  op;
        logic [63:0] lit;
        bit          has_exp;
        t_res        exp_res;
    } t_row;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [3:0]  i_operation = '0;
    logic [63:0] i_literal = '0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_print_valid, o_emit_valid;
    logic [1:0]  o_status;
    logic [63:0] o_print_value;
    logic [7:0]  o_emit_char;
    logic [6:0]  o_depth_after;

    forth_data_stack_alu_top u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: its own copy of the stack
    logic [63:0] model_stack [STACK_DEPTH];
    int          model_depth;
    t_res        pending_res [$];
    int          errors;
    int          send_idle_pct;   // sender gap chance per cycle, percent
    int          recv_idle_pct;   // receiver stall chance per cycle, percent
    bit          hold_off;        // long receiver stall in progress
    int          quiet_cycles = 0;

    function automatic t_res stack_exec(logic [3:0] op, logic [63:0] lit);
        t_res r;
        int need, d;
        logic [63:0] t, s, x1, q, rm, mn, md;
        r = '0;
        d = model_depth;
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVMOD, OP_SWAP: need = 2;
            OP_ROT: need = 3;
            OP_DUP, OP_DROP, OP_PRINT, OP_EMIT: need = 1;
            default: need = 0;
        endcase
        if (op <= OP_EMIT && d < need) begin
            r.status = ST_UNDER;
            model_depth = 0;
        end else begin
            t = (d >= 1) ? model_stack[d-1] : '0;
            s = (d >= 2) ? model_stack[d-2] : '0;
            case (op)
                OP_PUSH, OP_DUP: begin
                    if (d >= STACK_DEPTH) r.status = ST_OVER;
                    else begin
                        model_stack[d] = (op == OP_PUSH) ? lit : t;
                        model_depth = d + 1;
                    end
                end
                OP_ADD: begin model_stack[d-2] = s + t; model_depth = d - 1; end
                OP_SUB: begin model_stack[d-2] = s - t; model_depth = d - 1; end
                OP_MUL: begin model_stack[d-2] = s * t; model_depth = d - 1; end
                OP_DIV, OP_DIVMOD: begin
                    if (t == '0) r.status = ST_DIVZERO;
                    else begin
                        // Work on magnitudes; most negative / -1 wraps naturally
                        mn = s[63] ? -s : s;
                        md = t[63] ? -t : t;
                        q  = mn / md;
                        rm = mn % md;
                        if (s[63] != t[63]) q = -q;
                        if (s[63]) rm = -rm;
                        if (op == OP_DIV) begin
                            model_stack[d-2] = q;
                            model_depth = d - 1;
                        end else begin
                            model_stack[d-2] = rm;
                            model_stack[d-1] = q;
                        end
                    end
                end
                OP_SWAP: begin model_stack[d-2] = t; model_stack[d-1] = s; end
                OP_ROT: begin
                    x1 = model_stack[d-3];
                    model_stack[d-3] = s;
                    model_stack[d-2] = t;
                    model_stack[d-1] = x1;
                end
                OP_DROP: model_depth = d - 1;
                OP_PRINT: begin r.pv = 1'b1; r.pval = t; model_depth = d - 1; end
                OP_EMIT: begin r.ev = 1'b1; r.ech = t[7:0]; model_depth = d - 1; end
                default: ;
            endcase
        end
        r.depth = model_depth[6:0];
        return r;
    endfunction

    // Offer one beat, hold it until accepted, then record the expectation.
    // Drop valid only while idling, so back-to-back beats keep it high.
    task automatic send_beat(logic [3:0] op, logic [63:0] lit, bit chk, t_res fixed);
        t_res r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_literal   <= lit;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = stack_exec(op, lit);
        if (chk && r != fixed) begin
            $error("table row %0d/%h predicted %p, typed %p", op, lit, r, fixed);
            errors++;
        end
        pending_res.push_back(r);
    endtask

    function automatic t_res mk(logic [1:0] st, logic [6:0] dp, logic pv = 0,
                                logic [63:0] pval = 0, logic ev = 0, logic [7:0] ec = 0);
        t_res r;
        r.status = st; r.pv = pv; r.pval = pval; r.ev = ev; r.ech = ec; r.depth = dp;
        return r;
    endfunction

    // Result side: stall at random, check every accepted beat in order
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                quiet_cycles <= 0;
                if (pending_res.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    want = pending_res.pop_front();
                    if (o_status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, o_status); errors++;
                    end
                    if (o_print_valid !== want.pv) begin
                        $error("print_valid exp %0d got %0d", want.pv, o_print_valid);
                        errors++;
                    end
                    if (o_print_value !== want.pval) begin
                        $error("print_value exp %h got %h", want.pval, o_print_value);
                        errors++;
                    end
                    if (o_emit_valid !== want.ev) begin
                        $error("emit_valid exp %0d got %0d", want.ev, o_emit_valid);
                        errors++;
                    end
                    if (o_emit_char !== want.ech) begin
                        $error("emit_char exp %h got %h", want.ech, o_emit_char); errors++;
                    end
                    if (o_depth_after !== want.depth) begin
                        $error("depth_after exp %0d got %0d", want.depth, o_depth_after);
                        errors++;
                    end
                end
            end else if (!(i_valid && !o_stall)) begin
                quiet_cycles <= quiet_cycles + 1;
            end else begin
                quiet_cycles <= 0;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb_top failed");
                $finish;
            end
            i_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Pressure: stall the receiver for a long stretch so the input backs up
    task automatic long_hold(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // Random operand: extremes often, small values for division now and then
    function automatic logic [63:0] rand_lit();
        case ($urandom_range(5))
            0: return MOST_NEG;
            1: return ALL_ONES;
            2: return 64'($urandom_range(7));
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed: push when shallow, drop when deep, then mixed ops; occasional noise
    function automatic logic [3:0] rand_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) return 4'($urandom_range(15));
        if (model_depth < 3 && pick < 70) return OP_PUSH;
        if (model_depth > 50 && pick < 60) return OP_DROP;
        if (pick < 35) return OP_PUSH;
        return 4'($urandom_range(OP_EMIT));
    endfunction

    t_row table_rows [$];

    initial begin
        int phase, n;
        errors = 0; hold_off = 0;
        send_idle_pct = 6; recv_idle_pct = 70;
        for (int k = 0; k < STACK_DEPTH; k++) model_stack[k] = '0;
        model_depth = 0;
        // Directed table: underflow after reset, extremes, division corner cases
        table_rows = '{
            '{OP_ADD, 0, 1, mk(ST_UNDER, 0)},
            '{OP_DUP, 0, 1, mk(ST_UNDER, 0)},
            '{OP_PUSH, MOST_NEG, 1, mk(ST_OK, 1)},
            '{OP_PRINT, 0, 1, mk(ST_OK, 0, 1, MOST_NEG)},
            '{OP_PUSH, ALL_ONES, 1, mk(ST_OK, 1)},
            '{OP_EMIT, 0, 1, mk(ST_OK, 0, 0, 0, 1, 8'hFF)},
            '{OP_PUSH, MOST_NEG, 0, '0},
            '{OP_PUSH, ALL_ONES, 0, '0},
            '{OP_DIVMOD, 0, 0, '0},
            '{OP_PUSH, 0, 0, '0},
            '{OP_DIV, 0, 1, mk(ST_DIVZERO, 3)},
            '{OP_DIVMOD, 0, 1, mk(ST_DIVZERO, 3)},
            '{OP_DROP, 0, 0, '0},
            '{OP_PUSH, -64'sd7, 0, '0},
            '{OP_PUSH, 64'sd2, 0, '0},
            '{OP_DIVMOD, 0, 0, '0},
            '{OP_ROT, 0, 0, '0},
            '{OP_SWAP, 0, 0, '0},
            '{OP_MUL, 0, 0, '0},
            '{OP_SUB, 0, 0, '0},
            '{OP_DIV, 0, 0, '0},
            '{4'd13, 64'h1234, 0, '0},
            '{OP_ROT, 0, 1, mk(ST_UNDER, 0)},
            '{OP_DROP, 0, 1, mk(ST_UNDER, 0)}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_rows[k])
            send_beat(table_rows[k].op, table_rows[k].lit, table_rows[k].has_exp,
                      table_rows[k].exp_res);
        // Fill to the limit to hit overflow on both push and dup
        for (int k = 0; k < STACK_DEPTH; k++) send_beat(OP_PUSH, rand_lit(), 0, '0);
        send_beat(OP_PUSH, 64'h5, 1, mk(ST_OVER, 7'(STACK_DEPTH)));
        send_beat(OP_DUP, 0, 1, mk(ST_OVER, 7'(STACK_DEPTH)));
        // Random phases with changing idle pattern
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 6 : 0;
            n = 0;
            fork
                if (phase == 2) long_hold(300);
                while (n < 500) begin
                    send_beat(rand_op(), rand_lit(), 0, '0);
                    n++;
                end
            join
        end
        i_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule

[sim.f]
rtl/core/fdsa_pkg.sv
rtl/core/fdsa_ram.sv
rtl/core/fdsa_div.sv
rtl/core/fdsa_dp.sv
rtl/core/fdsa_ctrl.sv
rtl/core/forth_data_stack_alu_top.sv
dv/tb_top.sv
